/* rtl/core/ptoc_pkg.sv */
// Shared widths, constants and types of the pixel to occupancy classifier.
package ptoc_pkg;

    localparam int CHANNEL_BITS  = 8;
    localparam int FRACTION_BITS = 16;
    localparam int LEVEL_BITS    = 16;
    localparam int LEVEL_W       = LEVEL_BITS + 1;
    localparam int OCC_W         = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = LEVEL_W;

    // channel sum and the shade denominator
    localparam int SUM_W = CHANNEL_BITS + 2;
    localparam int CMAX  = (1 << CHANNEL_BITS) - 1;
    localparam int DEN3  = 3 * CMAX;
    localparam int DEN2  = 2 * DEN3;

    // shade = floor((sum * 2^(F+1) + DEN3) / DEN2) by reciprocal and one correction
    localparam int SHADE_W   = FRACTION_BITS + 1;
    localparam int N_W       = SUM_W + FRACTION_BITS + 2;
    localparam int RECIP_W   = N_W + 2 - $clog2(DEN2);
    localparam int PROD_W    = N_W + RECIP_W;
    localparam int CHK_W     = SHADE_W + $clog2(DEN2) + 1;
    localparam longint unsigned RECIP_L = (longint'(1) << N_W) / longint'(DEN2) + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam logic [SHADE_W-1:0] FULL_Q = SHADE_W'(1) << FRACTION_BITS;

    // raw value = floor((sum * 510 + DEN3) / DEN2), same scheme
    localparam int RAW_K       = 510;
    localparam int RAW_N_W     = SUM_W + 10;
    localparam int RAW_RECIP_W = RAW_N_W + 2 - $clog2(DEN2);
    localparam int RAW_PROD_W  = RAW_N_W + RAW_RECIP_W;
    localparam int RAW_Q_W     = 9;
    localparam int RAW_CHK_W   = RAW_Q_W + $clog2(DEN2) + 1;
    localparam longint unsigned RAW_RECIP_L =
        (longint'(1) << RAW_N_W) / longint'(DEN2) + 1;
    localparam logic [RAW_RECIP_W-1:0] RAW_RECIP = RAW_RECIP_W'(RAW_RECIP_L);

    // common scale of occupancy and levels for the threshold tests
    localparam int MIN_FL = (FRACTION_BITS < LEVEL_BITS) ? FRACTION_BITS : LEVEL_BITS;
    localparam int MAX_FL = (FRACTION_BITS < LEVEL_BITS) ? LEVEL_BITS : FRACTION_BITS;
    localparam int SH_OCC = LEVEL_BITS - MIN_FL;
    localparam int SH_LVL = FRACTION_BITS - MIN_FL;
    localparam int CMP_W  = MAX_FL + 1;

    // ramp divider
    localparam int QB        = 7;
    localparam int NUM_W     = CMP_W + QB;
    localparam int OCC_SCALE = 100;

    localparam logic [OCC_W-1:0] OCC_FULL    = OCC_W'(100);
    localparam logic [OCC_W-1:0] OCC_FREE    = OCC_W'(0);
    localparam logic [OCC_W-1:0] OCC_UNKNOWN = OCC_W'(255);

    localparam logic [LEVEL_W-1:0] FREE_RESET     = LEVEL_W'(16384);
    localparam logic [LEVEL_W-1:0] OCCUPIED_RESET = LEVEL_W'(42598);

    typedef enum logic [1:0] {
        MODE_TRINARY = 2'd0,
        MODE_SCALE   = 2'd1,
        MODE_RAW     = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAP_MODE       = 2'd0,
        REG_INVERT_SHADE   = 2'd1,
        REG_FREE_LEVEL     = 2'd2,
        REG_OCCUPIED_LEVEL = 2'd3
    } t_reg_idx;

    // what travels beside the ramp division
    typedef struct packed {
        logic             ramp;
        logic [OCC_W-1:0] fixed;
    } t_tag;

endpackage

/* rtl/core/pixel_to_occupancy_classifier_core.sv */
// Top level of the pixel to occupancy classifier: pixel stream in, occupancy percent out.
//
// One RGB pixel with an opacity value goes in per transfer and one occupancy
// percent (-1 for unknown) comes out per transfer, in order. The block takes a
// pixel every cycle while the skid register is empty; a result passes through
// seven stages for the channel sum, the reciprocal multiply that turns the
// sum into a Q1.16 shade and its one-step correction, the occupancy and the
// threshold tests, then seven stages of the bit-per-stage ramp divider, then
// the rounding into the output register. All stages advance together; a
// skid register behind the output register keeps taking pixels while a
// result waits, and the pipeline holds only once that skid register is full.
// Configuration registers are written through the plain write port and are
// read live by the stages, so write them only while no pixel is in flight.
module pixel_to_occupancy_classifier_core import ptoc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // pixel channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [CHANNEL_BITS-1:0] i_red,
    input  logic [CHANNEL_BITS-1:0] i_green,
    input  logic [CHANNEL_BITS-1:0] i_blue,
    input  logic [CHANNEL_BITS-1:0] i_opacity,
    // occupancy channel
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [OCC_W-1:0] o_occupancy,
    // configuration write port
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [1:0]         r_map_mode;
    logic               r_invert;
    logic [LEVEL_W-1:0] r_free_level;
    logic [LEVEL_W-1:0] r_occd_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_mode   <= MODE_TRINARY;
            r_invert     <= 1'b0;
            r_free_level <= FREE_RESET;
            r_occd_level <= OCCUPIED_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MAP_MODE:       r_map_mode   <= i_cfg_data[1:0];
                REG_INVERT_SHADE:   r_invert     <= i_cfg_data[0];
                REG_FREE_LEVEL:     r_free_level <= i_cfg_data;
                REG_OCCUPIED_LEVEL: r_occd_level <= i_cfg_data;
                default:            r_map_mode   <= r_map_mode;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control: every stage advances while the skid register is
    // empty; valid bits shift along with the data.
    // ---------------------------------------------------------------
    logic       w_en;
    logic [6:0] r_vld;
    logic       r_skid_valid;

    assign w_en       = !r_skid_valid;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[5:0], i_in_valid};
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: channel sum, opacity flag
    // ---------------------------------------------------------------
    logic [SUM_W-1:0] r_sum1;
    logic             r_opq1;

    // ---------------------------------------------------------------
    // Stage 2: numerators of the shade and raw divisions
    // ---------------------------------------------------------------
    logic [N_W-1:0]     r_n2;
    logic [RAW_N_W-1:0] r_rn2;
    logic               r_opq2;

    // ---------------------------------------------------------------
    // Stage 3: multiply by the reciprocals
    // ---------------------------------------------------------------
    logic [PROD_W-1:0]     r_prod3;
    logic [RAW_PROD_W-1:0] r_rprod3;
    logic [N_W-1:0]        r_n3;
    logic [RAW_N_W-1:0]    r_rn3;
    logic                  r_opq3;

    // ---------------------------------------------------------------
    // Stage 4: correct the estimates by one where they overshoot
    // ---------------------------------------------------------------
    logic [SHADE_W-1:0]   w_q0;
    logic [CHK_W-1:0]     w_chk;
    logic [RAW_Q_W-1:0]   w_rq0;
    logic [RAW_CHK_W-1:0] w_rchk;
    logic [SHADE_W-1:0]   r_shade4;
    logic [RAW_Q_W-1:0]   r_raw4;
    logic                 r_opq4;

    assign w_q0   = r_prod3[N_W +: SHADE_W];
    assign w_chk  = CHK_W'(w_q0) * CHK_W'(DEN2);
    assign w_rq0  = r_rprod3[RAW_N_W +: RAW_Q_W];
    assign w_rchk = RAW_CHK_W'(w_rq0) * RAW_CHK_W'(DEN2);

    // ---------------------------------------------------------------
    // Stage 5: occupancy from shade
    // ---------------------------------------------------------------
    logic [SHADE_W-1:0] r_occ5;
    logic [RAW_Q_W-1:0] r_raw5;
    logic               r_opq5;

    // ---------------------------------------------------------------
    // Stage 6: threshold tests and the decision per mode
    // ---------------------------------------------------------------
    logic [CMP_W-1:0] w_occ_s;
    logic [CMP_W-1:0] w_free_s;
    logic [CMP_W-1:0] w_occd_s;
    logic [CMP_W-1:0] w_span;
    logic             w_above;
    logic             w_below;
    t_tag             w_tag6;
    t_tag             r_tag6;
    logic [CMP_W-1:0] r_d6;
    logic [CMP_W-1:0] r_s6;

    assign w_occ_s  = CMP_W'(r_occ5) << SH_OCC;
    assign w_free_s = CMP_W'(r_free_level) << SH_LVL;
    assign w_occd_s = CMP_W'(r_occd_level) << SH_LVL;
    assign w_span   = w_occd_s - w_free_s;
    assign w_above  = (w_occd_s < w_occ_s);
    assign w_below  = (w_occ_s < w_free_s);

    always_comb begin
        w_tag6.ramp  = 1'b0;
        w_tag6.fixed = OCC_UNKNOWN;
        case (r_map_mode)
            MODE_RAW: begin
                w_tag6.fixed = (r_raw5 <= RAW_Q_W'(OCC_SCALE)) ?
                               r_raw5[OCC_W-1:0] : OCC_UNKNOWN;
            end
            MODE_TRINARY: begin
                if (w_above) begin
                    w_tag6.fixed = OCC_FULL;
                end else if (w_below) begin
                    w_tag6.fixed = OCC_FREE;
                end
            end
            MODE_SCALE: begin
                // pixels with a nonzero opacity value stay unknown; a zero-width ramp reads free
                if (r_opq5) begin
                    w_tag6.fixed = OCC_UNKNOWN;
                end else if (w_above) begin
                    w_tag6.fixed = OCC_FULL;
                end else if (w_below) begin
                    w_tag6.fixed = OCC_FREE;
                end else if (w_span == '0) begin
                    w_tag6.fixed = OCC_FREE;
                end else begin
                    w_tag6.ramp = 1'b1;
                end
            end
            default: w_tag6.fixed = OCC_UNKNOWN;
        endcase
    end

    // ---------------------------------------------------------------
    // Stage 7: ramp numerator
    // ---------------------------------------------------------------
    logic [NUM_W-1:0] r_num7;
    logic [CMP_W-1:0] r_den7;
    t_tag             r_tag7;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum1   <= SUM_W'(i_red) + SUM_W'(i_green) + SUM_W'(i_blue);
            r_opq1   <= |i_opacity;

            r_n2     <= (N_W'(r_sum1) << (FRACTION_BITS + 1)) + N_W'(DEN3);
            r_rn2    <= RAW_N_W'(r_sum1) * RAW_N_W'(RAW_K) + RAW_N_W'(DEN3);
            r_opq2   <= r_opq1;

            r_prod3  <= PROD_W'(r_n2) * PROD_W'(RECIP);
            r_rprod3 <= RAW_PROD_W'(r_rn2) * RAW_PROD_W'(RAW_RECIP);
            r_n3     <= r_n2;
            r_rn3    <= r_rn2;
            r_opq3   <= r_opq2;

            r_shade4 <= (w_chk > CHK_W'(r_n3)) ? (w_q0 - SHADE_W'(1)) : w_q0;
            r_raw4   <= (w_rchk > RAW_CHK_W'(r_rn3)) ? (w_rq0 - RAW_Q_W'(1)) : w_rq0;
            r_opq4   <= r_opq3;

            r_occ5   <= r_invert ? r_shade4 : (FULL_Q - r_shade4);
            r_raw5   <= r_raw4;
            r_opq5   <= r_opq4;

            r_tag6   <= w_tag6;
            r_d6     <= w_occ_s - w_free_s;
            r_s6     <= w_span;

            r_num7   <= NUM_W'(r_d6) * NUM_W'(OCC_SCALE);
            r_den7   <= r_s6;
            r_tag7   <= r_tag6;
        end
    end

    // ---------------------------------------------------------------
    // Stages 8 to 14: ramp division
    // ---------------------------------------------------------------
    logic             w_div_valid;
    logic [QB-1:0]    w_quo;
    logic [NUM_W-1:0] w_rem;
    logic [CMP_W-1:0] w_div_den;
    t_tag             w_div_tag;

    ptoc_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_vld[6]),
        .i_num   (r_num7),
        .i_den   (r_den7),
        .i_tag   (r_tag7),
        .o_valid (w_div_valid),
        .o_quo   (w_quo),
        .o_rem   (w_rem),
        .o_den   (w_div_den),
        .o_tag   (w_div_tag)
    );

    // ---------------------------------------------------------------
    // Round half to even and pick the ramp or the fixed result
    // ---------------------------------------------------------------
    logic [CMP_W:0]   w_rem2;
    logic [CMP_W:0]   w_span2;
    logic             w_round_up;
    logic [OCC_W-1:0] w_fin_occ;

    // remainder is below the span here, so its low bits hold all of it
    assign w_rem2     = {w_rem[CMP_W-1:0], 1'b0};
    assign w_span2    = {1'b0, w_div_den};
    assign w_round_up = (w_rem2 > w_span2) || ((w_rem2 == w_span2) && w_quo[0]);
    assign w_fin_occ  = w_div_tag.ramp ?
                        (OCC_W'(w_quo) + OCC_W'(w_round_up)) : w_div_tag.fixed;

    // ---------------------------------------------------------------
    // Output register and skid register
    // ---------------------------------------------------------------
    logic             r_out_valid;
    logic [OCC_W-1:0] r_out_occ;
    logic [OCC_W-1:0] r_skid_occ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // drain the skid register into the output once the result leaves
            if (i_out_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (r_out_valid && !i_out_ready) begin
            // hold the output, park a new result aside
            r_skid_valid <= w_div_valid;
        end else begin
            r_out_valid <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_out_ready) begin
                r_out_occ <= r_skid_occ;
            end
        end else if (r_out_valid && !i_out_ready) begin
            r_skid_occ <= w_fin_occ;
        end else begin
            r_out_occ <= w_fin_occ;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_occupancy = $signed(r_out_occ);

endmodule

/* rtl/core/ptoc_divider.sv */
// Pipelined restoring divider, one quotient bit per stage, for the scale ramp.
module ptoc_divider import ptoc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [CMP_W-1:0] i_den,
    input  t_tag             i_tag,
    output logic             o_valid,
    output logic [QB-1:0]    o_quo,
    output logic [NUM_W-1:0] o_rem,
    output logic [CMP_W-1:0] o_den,
    output t_tag             o_tag
);

    logic [QB-1:0]    r_vld;
    logic [NUM_W-1:0] r_rem [QB];
    logic [QB-1:0]    r_quo [QB];
    logic [CMP_W-1:0] r_den [QB];
    t_tag             r_tag [QB];

    logic [NUM_W-1:0] w_rem [QB+1];
    logic [QB-1:0]    w_quo [QB+1];
    logic [CMP_W-1:0] w_den [QB+1];
    t_tag             w_tag [QB+1];

    assign w_rem[0] = i_num;
    assign w_quo[0] = '0;
    assign w_den[0] = i_den;
    assign w_tag[0] = i_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QB-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [NUM_W-1:0] trial;
        logic             fits;

        // try the divisor at the weight of quotient bit QB-1-k
        assign trial = NUM_W'(w_den[k]) << (QB - 1 - k);
        assign fits  = (w_rem[k] >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= fits ? (w_rem[k] - trial) : w_rem[k];
                r_quo[k] <= {w_quo[k][QB-2:0], fits};
                r_den[k] <= w_den[k];
                r_tag[k] <= w_tag[k];
            end
        end

        assign w_rem[k+1] = r_rem[k];
        assign w_quo[k+1] = r_quo[k];
        assign w_den[k+1] = r_den[k];
        assign w_tag[k+1] = r_tag[k];
    end

    assign o_valid = r_vld[QB-1];
    assign o_quo   = w_quo[QB];
    assign o_rem   = w_rem[QB];
    assign o_den   = w_den[QB];
    assign o_tag   = w_tag[QB];

endmodule

/* test/tb.sv */
// Testbench for the pixel to occupancy classifier core.
`timescale 1ns / 1ps

module tb;
    import ptoc_pkg::*;

    localparam int RUN_LIMIT       = 600000;  // cycles before the run is declared hung
    localparam int SETTLE_CYCLES   = 20;      // longer than the pipeline from pixel to result
    localparam int HOLD_OFF_CYCLES = 300;     // long sink stall that fills the pipeline

    // Divisor of the channel sum and the full scale of the raw average.
    localparam longint unsigned SHADE_DEN = 3 * ((1 << CHANNEL_BITS) - 1);
    localparam longint unsigned RAW_SCALE = 255;
    localparam longint unsigned PERCENT   = 100;

    // Mode code that the block does not define; it must answer unknown.
    localparam logic [1:0] MODE_UNDEFINED = 2'd3;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [CHANNEL_BITS-1:0] i_red;
    logic [CHANNEL_BITS-1:0] i_green;
    logic [CHANNEL_BITS-1:0] i_blue;
    logic [CHANNEL_BITS-1:0] i_opacity;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic signed [OCC_W-1:0] o_occupancy;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    // Local copy of the register file, updated at each write.
    logic [1:0]         cur_mode     = MODE_TRINARY;
    logic               cur_invert   = 1'b0;
    logic [LEVEL_W-1:0] cur_free     = FREE_RESET;
    logic [LEVEL_W-1:0] cur_occupied = OCCUPIED_RESET;

    // Occupancy values predicted for pixels already taken, oldest first.
    logic [OCC_W-1:0] pending_occupancy[$];

    // Knobs set by the test sequence for the source and for the sink process.
    logic src_no_gap    = 1'b0;
    logic sink_no_stall = 1'b0;
    logic hold_off_req  = 1'b0;

    int cycle_count        = 0;
    int mismatch_count     = 0;
    int pixels_sent        = 0;
    int results_checked    = 0;
    int settings_used      = 0;
    int input_stall_cycles = 0;

    pixel_to_occupancy_classifier_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_opacity   (i_opacity),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_occupancy (o_occupancy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Occupancy that the block must produce for one pixel under the current registers.
    // All tests run on a common fixed-point scale so that they are exact.
    function automatic logic [OCC_W-1:0] predict_occupancy(
        input logic [CHANNEL_BITS-1:0] r,
        input logic [CHANNEL_BITS-1:0] g,
        input logic [CHANNEL_BITS-1:0] b,
        input logic [CHANNEL_BITS-1:0] a
    );
        longint unsigned sum, shade_q, occ_q, occ_w, free_w, occd_w;
        longint unsigned span, num, quo, rem;
        sum     = 64'(r) + 64'(g) + 64'(b);
        shade_q = (2 * (sum << FRACTION_BITS) + SHADE_DEN) / (2 * SHADE_DEN);
        occ_q   = cur_invert ? shade_q : (64'd1 << FRACTION_BITS) - shade_q;
        occ_w   = occ_q << LEVEL_BITS;
        free_w  = 64'(cur_free) << FRACTION_BITS;
        occd_w  = 64'(cur_occupied) << FRACTION_BITS;
        case (cur_mode)
            MODE_RAW: begin
                // rounded average of the channels, straight from the sum
                quo = (2 * sum * RAW_SCALE + SHADE_DEN) / (2 * SHADE_DEN);
                return (quo <= PERCENT) ? OCC_W'(quo) : OCC_UNKNOWN;
            end
            MODE_TRINARY: begin
                if (occd_w < occ_w) return OCC_FULL;
                if (occ_w < free_w) return OCC_FREE;
                return OCC_UNKNOWN;
            end
            MODE_SCALE: begin
                if (a != '0) return OCC_UNKNOWN;
                if (occd_w < occ_w) return OCC_FULL;
                if (occ_w < free_w) return OCC_FREE;
                span = occd_w - free_w;
                // zero span: occupancy sits on both levels at once
                if (span == 0) return OCC_FREE;
                num = (occ_w - free_w) * PERCENT;
                quo = num / span;
                rem = num % span;
                // round half to even
                if (2 * rem > span || (2 * rem == span && quo[0])) quo++;
                return OCC_W'(quo);
            end
            default: return OCC_UNKNOWN;
        endcase
    endfunction

    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Offer one pixel and return at the edge where it transfers. Valid stays high
    // on return; the caller either offers the next pixel or drains in the same step.
    task automatic send_pixel(
        input logic [CHANNEL_BITS-1:0] r,
        input logic [CHANNEL_BITS-1:0] g,
        input logic [CHANNEL_BITS-1:0] b,
        input logic [CHANNEL_BITS-1:0] a
    );
        int gap;
        gap = src_no_gap ? 0 : idle_length();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_red      <= r;
        i_green    <= g;
        i_blue     <= b;
        i_opacity  <= a;
        do @(posedge i_clk); while (!o_in_ready);
        pending_occupancy.push_back(predict_occupancy(r, g, b, a));
        pixels_sent++;
    endtask

    task automatic send_random_pixel();
        int roll;
        logic [CHANNEL_BITS-1:0] r, g, b, a;
        roll = $urandom_range(0, 9);
        if (roll < 3) begin
            // dark pixels, whose raw average stays within 0..120
            r = CHANNEL_BITS'($urandom_range(0, 120));
            g = CHANNEL_BITS'($urandom_range(0, 120));
            b = CHANNEL_BITS'($urandom_range(0, 120));
        end else if (roll < 4) begin
            r = CHANNEL_BITS'($urandom_range(0, 255));
            g = r;
            b = r;
        end else begin
            r = CHANNEL_BITS'($urandom_range(0, 255));
            g = CHANNEL_BITS'($urandom_range(0, 255));
            b = CHANNEL_BITS'($urandom_range(0, 255));
        end
        a = ($urandom_range(0, 1) == 0) ? '0 : CHANNEL_BITS'($urandom_range(1, 255));
        send_pixel(r, g, b, a);
    endtask

    // Drop valid, wait until every predicted result has come back, then let the
    // pipeline go quiet so that register writes see an idle block.
    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (pending_occupancy.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers on consecutive edges; call only on an idle block.
    task automatic apply_settings(
        input logic [1:0]         mode,
        input logic               invert,
        input logic [LEVEL_W-1:0] free_lvl,
        input logic [LEVEL_W-1:0] occd_lvl
    );
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_MAP_MODE;
        i_cfg_data <= CFG_DATA_W'(mode);
        @(posedge i_clk);
        cur_mode = mode;
        i_cfg_idx  <= REG_INVERT_SHADE;
        i_cfg_data <= CFG_DATA_W'(invert);
        @(posedge i_clk);
        cur_invert = invert;
        i_cfg_idx  <= REG_FREE_LEVEL;
        i_cfg_data <= CFG_DATA_W'(free_lvl);
        @(posedge i_clk);
        cur_free = free_lvl;
        i_cfg_idx  <= REG_OCCUPIED_LEVEL;
        i_cfg_data <= CFG_DATA_W'(occd_lvl);
        @(posedge i_clk);
        cur_occupied = occd_lvl;
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [LEVEL_W-1:0] random_level();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return LEVEL_W'(65536);
            2: return LEVEL_W'(131071);
            3: return LEVEL_W'($urandom_range(65537, 131071));
            default: return LEVEL_W'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic apply_random_settings();
        logic [1:0]         mode;
        logic [LEVEL_W-1:0] free_lvl, occd_lvl, swap;
        int                 roll;
        mode     = ($urandom_range(0, 19) == 0) ? MODE_UNDEFINED : 2'($urandom_range(0, 2));
        free_lvl = random_level();
        occd_lvl = random_level();
        roll     = $urandom_range(0, 9);
        if (roll == 0) begin
            occd_lvl = free_lvl;
        end else if (roll < 8 && free_lvl > occd_lvl) begin
            swap     = free_lvl;
            free_lvl = occd_lvl;
            occd_lvl = swap;
        end
        apply_settings(mode, 1'($urandom_range(0, 1)), free_lvl, occd_lvl);
    endtask

    // Registers as they come out of reset: trinary, not inverted.
    task automatic test_default_trinary();
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128, 8'd0);
        drain_pipeline();
    endtask

    task automatic test_inverted_trinary();
        apply_settings(MODE_TRINARY, 1'b1, FREE_RESET, OCCUPIED_RESET);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd0);
        drain_pipeline();
    endtask

    // Pixels with nonzero opacity go unknown; mid-gray with zero opacity lands on the ramp.
    task automatic test_scale_ramp();
        apply_settings(MODE_SCALE, 1'b0, FREE_RESET, OCCUPIED_RESET);
        send_pixel(8'd40, 8'd40, 8'd40, 8'd1);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128, 8'd0);
        send_pixel(8'd100, 8'd100, 8'd100, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd0, 8'd0);
        drain_pipeline();
    endtask

    // Equal levels give a zero-span ramp; an occupied level above one never gives full.
    task automatic test_level_corners();
        apply_settings(MODE_SCALE, 1'b0, LEVEL_W'(65536), LEVEL_W'(65536));
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd1, 8'd0, 8'd0, 8'd0);
        drain_pipeline();
        apply_settings(MODE_SCALE, 1'b0, '0, LEVEL_W'(131071));
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        drain_pipeline();
        apply_settings(MODE_TRINARY, 1'b0, '0, LEVEL_W'(131071));
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd0);
        drain_pipeline();
    endtask

    // Channel sums 300 and 301 round to 100; 302 rounds past it and goes unknown.
    task automatic test_raw_average();
        apply_settings(MODE_RAW, 1'b0, FREE_RESET, OCCUPIED_RESET);
        send_pixel(8'd100, 8'd100, 8'd100, 8'd0);
        send_pixel(8'd100, 8'd100, 8'd101, 8'd0);
        send_pixel(8'd100, 8'd101, 8'd101, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        drain_pipeline();
    endtask

    task automatic test_undefined_mode();
        apply_settings(MODE_UNDEFINED, 1'b0, FREE_RESET, OCCUPIED_RESET);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd0);
        drain_pipeline();
    endtask

    task automatic test_random_settings(input int phases, input int per_phase);
        repeat (phases) begin
            apply_random_settings();
            repeat (per_phase) send_random_pixel();
            drain_pipeline();
        end
    endtask

    // Back-to-back transfers on both sides with no idling at all.
    task automatic test_full_rate(input int count);
        apply_settings(MODE_SCALE, 1'b0, FREE_RESET, OCCUPIED_RESET);
        src_no_gap    = 1'b1;
        sink_no_stall = 1'b1;
        repeat (count) send_random_pixel();
        drain_pipeline();
        src_no_gap    = 1'b0;
        sink_no_stall = 1'b0;
    endtask

    // Hold the sink off long enough for the pipeline and skid register to fill,
    // while the source keeps offering; the input must stall and lose nothing.
    task automatic test_backpressure_fill(input int count);
        apply_random_settings();
        hold_off_req = 1'b1;
        src_no_gap   = 1'b1;
        repeat (count) send_random_pixel();
        drain_pipeline();
        src_no_gap = 1'b0;
    endtask

    // Sink: random stalls, short mostly, plus the long hold-off on request.
    initial begin : sink
        int stall;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (!sink_no_stall && $urandom_range(0, 99) < 30) begin
                stall = idle_length() + 1;
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Compare every result transfer against the oldest prediction.
    always @(posedge i_clk) begin : check_results
        logic [OCC_W-1:0] want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_ready) input_stall_cycles++;
            if (o_out_valid && i_out_ready) begin
                if (pending_occupancy.size() == 0) begin
                    report_mismatch($sformatf("occupancy %0d with no pixel pending",
                                              o_occupancy));
                end else begin
                    want = pending_occupancy.pop_front();
                    results_checked++;
                    if (o_occupancy !== want)
                        report_mismatch($sformatf("occupancy expected %0d, got %0d",
                                                  $signed(want), o_occupancy));
                end
            end
        end
    end

    // Hang guard: end the run if the cycle count runs past the limit.
    initial begin : watchdog
        wait (cycle_count >= RUN_LIMIT);
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        // Hold every input at a known value from time zero.
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_red      = '0;
        i_green    = '0;
        i_blue     = '0;
        i_opacity  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_MAP_MODE;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_trinary();
        test_inverted_trinary();
        test_scale_ramp();
        test_level_corners();
        test_raw_average();
        test_undefined_mode();
        test_random_settings(8, 120);
        test_full_rate(80);
        test_backpressure_fill(60);

        $display("tb: %0d pixels sent over %0d register settings, every mode and level corner",
                 pixels_sent, settings_used);
        $display("tb: %0d occupancy results checked, input held off for %0d cycles",
                 results_checked, input_stall_cycles);
        if (mismatch_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/ptoc_pkg.sv
rtl/core/ptoc_divider.sv
rtl/core/pixel_to_occupancy_classifier_core.sv
test/tb.sv
